FILE: sv/dtq_pkg.sv
// Shared types and constants for the delta timer queue.
package dtq_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  localparam int ID_W = 8;
  localparam int DELTA_W = 32;

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_DEL = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;

  localparam logic STAT_OK = 1'b0;
  localparam logic STAT_REJ = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_STAT,
    S_TRD,
    S_TCHK,
    S_TFIN,
    S_MOVE
  } state_t;

endpackage

FILE: sv/dtq_in_if.sv
// Request channel: operation word in.
interface dtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  timer_id;
  logic [31:0] delay_ticks;

  modport source (output valid, mode, timer_id, delay_ticks, input ready);
  modport sink (input valid, mode, timer_id, delay_ticks, output ready);
endinterface

FILE: sv/dtq_out_if.sv
// Response channel: status and expiry words out.
interface dtq_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] expired_id;
  logic       status;
  logic       last;

  modport source (output valid, kind, expired_id, status, last, input ready);
  modport sink (input valid, kind, expired_id, status, last, output ready);
endinterface

FILE: sv/dtq_mem.sv
// Timer entry memory: one write port, one registered read port.
module dtq_mem
  import dtq_pkg::*;
#(
  parameter int SLOTS = TIMER_SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] wa,
  input  entry_t        wd,
  input  logic [IW-1:0] ra,
  output entry_t        rq
);

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    rq <= mem[ra];
  end

endmodule

FILE: sv/delta_timer_queue_top.sv
// Delta-list timer queue: sequencer around a single entry memory.
// Add: full scan for duplicates and the insert position, then a shift pass.
// Delete: scan, then a compaction pass when the id is found.
// Tick: decrements the head delta, emits each expired id in turn, then compacts
// the remaining entries; expiry words wait while the response channel is held.
// One item at a time. Reset clears the count, sequencer, pending flags and output valid only.
module delta_timer_queue_top
  import dtq_pkg::*;
#(
  parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
  input logic      clk,
  input logic      rst,
  dtq_in_if.sink   req,
  dtq_out_if.source rsp
);

  localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam logic [CW-1:0] FULL = CW'(TIMER_SLOTS);

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] ra, ra_next;
  logic pv, pv_next;
  logic [IW-1:0] pa, pa_next;
  logic [ID_W-1:0] tid, tid_next;
  logic [DELTA_W-1:0] rem, rem_next;
  logic found, found_next;
  logic dup, dup_next;
  logic del_op, del_op_next;
  logic [CW-1:0] pos, pos_next;
  logic [DELTA_W-1:0] pdelta, pdelta_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] off, off_next;
  logic [CW-1:0] mv_first, mv_first_next;
  logic stat, stat_next;
  logic pend, pend_next;
  logic [ID_W-1:0] pend_id, pend_id_next;
  logic out_v, out_v_next;
  logic out_kind, out_kind_next;
  logic [ID_W-1:0] out_id, out_id_next;
  logic out_stat, out_stat_next;
  logic out_last, out_last_next;

  logic we;
  logic [IW-1:0] wa, rd_addr;
  entry_t wd, q;
  logic ofree;
  logic [DELTA_W-1:0] dec;

  dtq_mem #(.SLOTS(TIMER_SLOTS)) u_mem (
    .clk(clk), .we(we), .wa(wa), .wd(wd), .ra(rd_addr), .rq(q)
  );

  assign ofree = !out_v || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = out_v;
  assign rsp.kind = out_kind;
  assign rsp.expired_id = out_id;
  assign rsp.status = out_stat;
  assign rsp.last = out_last;
  assign dec = (k == '0 && q.delta != '0) ? q.delta - 1'b1 : q.delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      pv <= 1'b0;
      pend <= 1'b0;
      out_v <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      pv <= pv_next;
      pend <= pend_next;
      out_v <= out_v_next;
    end
  end

  always_ff @(posedge clk) begin
    ra <= ra_next;
    pa <= pa_next;
    tid <= tid_next;
    rem <= rem_next;
    found <= found_next;
    dup <= dup_next;
    del_op <= del_op_next;
    pos <= pos_next;
    pdelta <= pdelta_next;
    k <= k_next;
    off <= off_next;
    mv_first <= mv_first_next;
    stat <= stat_next;
    pend_id <= pend_id_next;
    out_kind <= out_kind_next;
    out_id <= out_id_next;
    out_stat <= out_stat_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ra_next = ra;
    pv_next = pv;
    pa_next = pa;
    tid_next = tid;
    rem_next = rem;
    found_next = found;
    dup_next = dup;
    del_op_next = del_op;
    pos_next = pos;
    pdelta_next = pdelta;
    k_next = k;
    off_next = off;
    mv_first_next = mv_first;
    stat_next = stat;
    pend_next = pend;
    pend_id_next = pend_id;
    out_v_next = out_v && !rsp.ready;
    out_kind_next = out_kind;
    out_id_next = out_id;
    out_stat_next = out_stat;
    out_last_next = out_last;
    we = 1'b0;
    wa = pa;
    wd = q;
    rd_addr = ra[IW-1:0];

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          tid_next = req.timer_id;
          ra_next = '0;
          pv_next = 1'b0;
          found_next = 1'b0;
          dup_next = 1'b0;
          pos_next = cnt;
          rem_next = req.delay_ticks;
          k_next = '0;
          pend_next = 1'b0;
          unique case (req.mode)
            MODE_ADD: begin
              del_op_next = 1'b0;
              if (req.delay_ticks == '0 || cnt == FULL) begin
                stat_next = STAT_REJ;
                state_next = S_STAT;
              end else begin
                state_next = S_SCAN;
              end
            end
            MODE_DEL: begin
              del_op_next = 1'b1;
              state_next = S_SCAN;
            end
            MODE_TICK: begin
              if (cnt != '0) begin
                state_next = S_TRD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ra < cnt) begin
          pv_next = 1'b1;
          pa_next = ra[IW-1:0];
          ra_next = ra + 1'b1;
        end else begin
          pv_next = 1'b0;
        end
        if (pv) begin
          if (del_op) begin
            if (!found && q.id == tid) begin
              found_next = 1'b1;
              pos_next = CW'(pa);
              pdelta_next = q.delta;
            end
          end else begin
            if (q.id == tid) begin
              dup_next = 1'b1;
            end
            if (!found) begin
              if (rem >= q.delta) begin
                rem_next = rem - q.delta;
              end else begin
                found_next = 1'b1;
                pos_next = CW'(pa);
                pdelta_next = q.delta - rem;
              end
            end
          end
        end else if (ra == cnt) begin
          if (del_op) begin
            if (found) begin
              off_next = CW'(1);
              ra_next = pos + 1'b1;
              mv_first_next = pos + 1'b1;
              state_next = S_MOVE;
            end else begin
              stat_next = STAT_OK;
              state_next = S_STAT;
            end
          end else if (dup) begin
            stat_next = STAT_REJ;
            state_next = S_STAT;
          end else begin
            ra_next = cnt;
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        rd_addr = IW'(ra - 1'b1);
        if (ra > pos) begin
          pv_next = 1'b1;
          pa_next = IW'(ra - 1'b1);
          ra_next = ra - 1'b1;
        end else begin
          pv_next = 1'b0;
        end
        if (pv) begin
          we = 1'b1;
          wa = IW'(CW'(pa) + 1'b1);
          wd = q;
          if (CW'(pa) == pos) begin
            wd.delta = pdelta;
          end
        end else if (ra <= pos) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        we = 1'b1;
        wa = pos[IW-1:0];
        wd.id = tid;
        wd.delta = rem;
        cnt_next = cnt + 1'b1;
        stat_next = STAT_OK;
        state_next = S_STAT;
      end
      S_STAT: begin
        if (ofree) begin
          out_v_next = 1'b1;
          out_kind_next = KIND_STATUS;
          out_id_next = '0;
          out_stat_next = stat;
          out_last_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TRD: begin
        rd_addr = k[IW-1:0];
        state_next = S_TCHK;
      end
      S_TCHK: begin
        rd_addr = k[IW-1:0];
        if (dec == '0) begin
          if (!pend || ofree) begin
            if (pend) begin
              out_v_next = 1'b1;
              out_kind_next = KIND_EXPIRED;
              out_id_next = pend_id;
              out_stat_next = STAT_OK;
              out_last_next = 1'b0;
            end
            pend_next = 1'b1;
            pend_id_next = q.id;
            k_next = k + 1'b1;
            state_next = ((k + 1'b1) < cnt) ? S_TRD : S_TFIN;
          end
        end else if (k == '0) begin
          we = 1'b1;
          wa = '0;
          wd.id = q.id;
          wd.delta = dec;
          state_next = S_IDLE;
        end else begin
          state_next = S_TFIN;
        end
      end
      S_TFIN: begin
        if (ofree) begin
          out_v_next = 1'b1;
          out_kind_next = KIND_EXPIRED;
          out_id_next = pend_id;
          out_stat_next = STAT_OK;
          out_last_next = 1'b1;
          pend_next = 1'b0;
          if (k < cnt) begin
            off_next = k;
            ra_next = k;
            mv_first_next = k;
            pdelta_next = '0;
            pv_next = 1'b0;
            del_op_next = 1'b0;
            state_next = S_MOVE;
          end else begin
            cnt_next = '0;
            state_next = S_IDLE;
          end
        end
      end
      S_MOVE: begin
        if (ra < cnt) begin
          pv_next = 1'b1;
          pa_next = ra[IW-1:0];
          ra_next = ra + 1'b1;
        end else begin
          pv_next = 1'b0;
        end
        if (pv) begin
          we = 1'b1;
          wa = IW'(CW'(pa) - off);
          wd = q;
          if (CW'(pa) == mv_first) begin
            wd.delta = q.delta + pdelta;
          end
        end else if (ra >= cnt) begin
          cnt_next = cnt - off;
          if (del_op) begin
            stat_next = STAT_OK;
            state_next = S_STAT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
